// ===== design/abkf_pkg.sv =====
// Shared types, constants and sign-extension and saturation helpers for the angle and bias Kalman filter.
`default_nettype none
package abkf_pkg;

    // Register and index widths.
    localparam int CFG_W  = 31;
    localparam int IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_ANGLE_Q = 2'd0;
    localparam logic [IDX_W-1:0] REG_BIAS_Q  = 2'd1;
    localparam logic [IDX_W-1:0] REG_MEAS_R  = 2'd2;

    // Register reset values, Q8.24.
    localparam logic [CFG_W-1:0] ANGLE_Q_RST = 31'd16777;
    localparam logic [CFG_W-1:0] BIAS_Q_RST  = 31'd50332;
    localparam logic [CFG_W-1:0] MEAS_R_RST  = 31'd503316;

    // Wide signed type for intermediate sums.
    typedef logic signed [71:0] t_wide;

    // Sign-extend a 32-bit value to the wide type.
    function automatic t_wide sx72(input logic [31:0] v);
        return t_wide'({{40{v[31]}}, v});
    endfunction

    // Clamp a wide value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input t_wide v);
        logic [31:0] res;
        if (v > t_wide'(64'sh0000_0000_7FFF_FFFF)) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -t_wide'(64'sh0000_0000_8000_0000)) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== design/angle_bias_kalman_filter.sv =====
// Two-state angle and gyro bias Kalman filter with a bit-serial multiplier and divider.
//
//  Channel   Signals                                         Direction
//  input     i_valid / o_ready, measured angle, rate, dt     in
//  result    o_valid / i_ready, angle, unbiased rate, bias   out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data                 in (write only)
//
// One transaction runs ten shift-add multiplies (four with the
// 16-bit time step at 16 steps each, six at 32 steps each) and two restoring
// divides of 56 steps each, all on one shared serial datapath under a sequencer.
// Reset is synchronous and active low; it clears the estimates and covariances
// and loads the noise registers with their defaults. A finished result waits in
// the output register while the next input transaction is already accepted.
`default_nettype none
module angle_bias_kalman_filter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_measured_angle,
    input  wire logic [31:0] i_measured_rate,
    input  wire logic [15:0] i_time_step,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_angle_output,
    output logic [31:0]      o_unbiased_rate,
    output logic [31:0]      o_bias_output,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [30:0] i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_RUN  = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    // Operation codes, in execution order.
    localparam logic [3:0] OP_M1 = 4'd0;   // dt * rate
    localparam logic [3:0] OP_M2 = 4'd1;   // dt * p11
    localparam logic [3:0] OP_M3 = 4'd2;   // dt * inner
    localparam logic [3:0] OP_M4 = 4'd3;   // bias noise * dt
    localparam logic [3:0] OP_D0 = 4'd4;   // gain k0
    localparam logic [3:0] OP_D1 = 4'd5;   // gain k1
    localparam logic [3:0] OP_M5 = 4'd6;   // k0 * y
    localparam logic [3:0] OP_M6 = 4'd7;   // k1 * y
    localparam logic [3:0] OP_M7 = 4'd8;   // k1 * p00
    localparam logic [3:0] OP_M8 = 4'd9;   // k1 * p01
    localparam logic [3:0] OP_M9 = 4'd10;  // k0 * p00
    localparam logic [3:0] OP_MA = 4'd11;  // k0 * p01

    localparam logic [5:0] STEPS_DT  = 6'd16;
    localparam logic [5:0] STEPS_MUL = 6'd32;
    localparam logic [5:0] STEPS_DIV = 6'd56;

    // Control state.
    logic [2:0] r_st, n_st;
    logic [3:0] r_op, n_op;
    logic [5:0] r_cnt, n_cnt;
    logic       r_ovalid, n_ovalid;

    // Filter state and configuration.
    logic [31:0] r_angle, n_angle, r_bias, n_bias;
    logic [31:0] r_p00, n_p00, r_p01, n_p01, r_p10, n_p10, r_p11, n_p11;
    logic [30:0] r_qa, n_qa, r_qb, n_qb, r_rn, n_rn;

    // Per-transaction working registers.
    logic [31:0] r_ma, n_ma, r_rate, n_rate, r_dp11, n_dp11, r_y, n_y;
    logic [31:0] r_k0, n_k0, r_k1, n_k1;
    logic [15:0] r_dt, n_dt;
    logic [31:0] r_oang, n_oang, r_orate, n_orate, r_obias, n_obias;

    // Serial datapath registers.
    logic [35:0]        r_mcand, n_mcand;
    logic [68:0]        r_acc, n_acc;
    logic               r_neg, n_neg;
    logic [32:0]        r_rem, n_rem, r_den, n_den;
    logic [55:0]        r_quo, n_quo;
    logic               r_dzero, n_dzero;
    logic signed [69:0] r_prod, n_prod;

    // Combinational helpers.
    logic               is_div;
    logic [5:0]         steps;
    logic signed [35:0] op_a, inner;
    logic signed [32:0] op_b;
    logic signed [33:0] div_s;
    logic [31:0]        div_num;
    logic [35:0]        abs_a;
    logic [32:0]        abs_b;
    logic [31:0]        abs_num;
    logic [33:0]        abs_s;
    logic [36:0]        mul_sum;
    logic [33:0]        div_t;
    logic               div_ge;
    logic [33:0]        div_diff;
    logic [67:0]        mul_mag;
    logic signed [69:0] mul_res;
    abkf_pkg::t_wide    quo_w, prod_w, sh16, sh24;

    assign o_ready         = (r_st == ST_IDLE);
    assign o_valid         = r_ovalid;
    assign o_angle_output  = r_oang;
    assign o_unbiased_rate = r_orate;
    assign o_bias_output   = r_obias;

    // Operand selection and iteration count for the current operation.
    always_comb begin
        is_div  = (r_op == OP_D0) || (r_op == OP_D1);
        inner   = 36'(signed'(r_dp11)) - 36'(signed'(r_p01)) - 36'(signed'(r_p10))
                + signed'({5'd0, r_qa});
        div_s   = 34'(signed'(r_p00)) + signed'({3'd0, r_rn});
        div_num = (r_op == OP_D1) ? r_p10 : r_p00;
        op_a    = '0;
        op_b    = '0;
        case (r_op)
            OP_M1:   begin op_a = 36'(signed'(r_rate)); op_b = signed'({17'd0, r_dt}); end
            OP_M2:   begin op_a = 36'(signed'(r_p11));  op_b = signed'({17'd0, r_dt}); end
            OP_M3:   begin op_a = inner;                op_b = signed'({17'd0, r_dt}); end
            OP_M4:   begin op_a = signed'({5'd0, r_qb}); op_b = signed'({17'd0, r_dt}); end
            OP_M5:   begin op_a = 36'(signed'(r_k0)); op_b = 33'(signed'(r_y));   end
            OP_M6:   begin op_a = 36'(signed'(r_k1)); op_b = 33'(signed'(r_y));   end
            OP_M7:   begin op_a = 36'(signed'(r_k1)); op_b = 33'(signed'(r_p00)); end
            OP_M8:   begin op_a = 36'(signed'(r_k1)); op_b = 33'(signed'(r_p01)); end
            OP_M9:   begin op_a = 36'(signed'(r_k0)); op_b = 33'(signed'(r_p00)); end
            OP_MA:   begin op_a = 36'(signed'(r_k0)); op_b = 33'(signed'(r_p01)); end
            default: begin op_a = '0; op_b = '0; end
        endcase
        case (r_op)
            OP_M1, OP_M2, OP_M3, OP_M4: steps = STEPS_DT;
            OP_D0, OP_D1:               steps = STEPS_DIV;
            default:                    steps = STEPS_MUL;
        endcase
        abs_a   = op_a[35] ? 36'(-op_a) : 36'(op_a);
        abs_b   = op_b[32] ? 33'(-op_b) : 33'(op_b);
        abs_num = div_num[31] ? 32'(-signed'(div_num)) : div_num;
        abs_s   = div_s[33] ? 34'(-div_s) : 34'(div_s);
    end

    // One step of the shift-add multiplier and of the restoring divider.
    always_comb begin
        mul_sum  = r_acc[68:32] + (r_acc[0] ? {1'b0, r_mcand} : 37'd0);
        div_t    = {r_rem, r_quo[55]};
        div_ge   = (div_t >= {1'b0, r_den});
        div_diff = div_t - {1'b0, r_den};
        mul_mag  = (steps == STEPS_DT) ? 68'(r_acc[68:16]) : r_acc[67:0];
        mul_res  = r_neg ? -signed'({2'b00, mul_mag}) : signed'({2'b00, mul_mag});
        quo_w    = r_neg ? -abkf_pkg::t_wide'({16'd0, r_quo}) : abkf_pkg::t_wide'({16'd0, r_quo});
        prod_w   = abkf_pkg::t_wide'(r_prod);
        sh16     = prod_w >>> 16;
        sh24     = prod_w >>> 24;
    end

    // Sequencer and state updates.
    always_comb begin
        n_st = r_st;  n_op = r_op;  n_cnt = r_cnt;  n_ovalid = r_ovalid;
        n_angle = r_angle;  n_bias = r_bias;
        n_p00 = r_p00;  n_p01 = r_p01;  n_p10 = r_p10;  n_p11 = r_p11;
        n_qa = r_qa;  n_qb = r_qb;  n_rn = r_rn;
        n_ma = r_ma;  n_rate = r_rate;  n_dp11 = r_dp11;  n_y = r_y;
        n_k0 = r_k0;  n_k1 = r_k1;  n_dt = r_dt;
        n_oang = r_oang;  n_orate = r_orate;  n_obias = r_obias;
        n_mcand = r_mcand;  n_acc = r_acc;  n_neg = r_neg;
        n_rem = r_rem;  n_den = r_den;  n_quo = r_quo;  n_dzero = r_dzero;
        n_prod = r_prod;

        // Configuration writes.
        if (i_cfg_we) begin
            case (i_cfg_idx)
                abkf_pkg::REG_ANGLE_Q: n_qa = i_cfg_data;
                abkf_pkg::REG_BIAS_Q:  n_qb = i_cfg_data;
                abkf_pkg::REG_MEAS_R:  n_rn = i_cfg_data;
                default:               ;
            endcase
        end

        // The output register empties when its transaction completes.
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_st)
            ST_IDLE: begin
                if (i_valid) begin
                    n_ma   = i_measured_angle;
                    n_dt   = i_time_step;
                    n_rate = abkf_pkg::sat32(abkf_pkg::sx72(i_measured_rate)
                                             - abkf_pkg::sx72(r_bias));
                    n_op   = OP_M1;
                    n_st   = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_cnt = '0;
                if (is_div) begin
                    n_quo   = {abs_num, 24'd0};
                    n_rem   = '0;
                    n_den   = abs_s[32:0];
                    n_neg   = div_num[31] ^ div_s[33];
                    n_dzero = (div_s == '0);
                end else begin
                    n_mcand = abs_a;
                    n_acc   = {37'd0, abs_b[31:0]};
                    n_neg   = op_a[35] ^ op_b[32];
                end
                n_st = ST_RUN;
            end
            ST_RUN: begin
                if (is_div) begin
                    n_rem = div_ge ? div_diff[32:0] : div_t[32:0];
                    n_quo = {r_quo[54:0], div_ge};
                end else begin
                    n_acc = {1'b0, mul_sum, r_acc[31:1]};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == steps - 6'd1) begin
                    n_st = ST_SIGN;
                end
            end
            ST_SIGN: begin
                if (is_div) begin
                    n_prod = r_dzero ? '0 : 70'(signed'(abkf_pkg::sat32(quo_w)));
                end else begin
                    n_prod = mul_res;
                end
                n_st = ST_DONE;
            end
            ST_DONE: begin
                case (r_op)
                    OP_M1: n_angle = abkf_pkg::sat32(abkf_pkg::sx72(r_angle) + sh16);
                    OP_M2: n_dp11  = sh16[31:0];
                    OP_M3: begin
                        n_p00 = abkf_pkg::sat32(abkf_pkg::sx72(r_p00) + sh16);
                        n_p01 = abkf_pkg::sat32(abkf_pkg::sx72(r_p01) - abkf_pkg::sx72(r_dp11));
                        n_p10 = abkf_pkg::sat32(abkf_pkg::sx72(r_p10) - abkf_pkg::sx72(r_dp11));
                    end
                    OP_M4: begin
                        n_p11 = abkf_pkg::sat32(abkf_pkg::sx72(r_p11) + sh16);
                        n_y   = abkf_pkg::sat32(abkf_pkg::sx72(r_ma) - abkf_pkg::sx72(r_angle));
                    end
                    OP_D0: n_k0    = r_prod[31:0];
                    OP_D1: n_k1    = r_prod[31:0];
                    OP_M5: n_angle = abkf_pkg::sat32(abkf_pkg::sx72(r_angle) + sh24);
                    OP_M6: n_bias  = abkf_pkg::sat32(abkf_pkg::sx72(r_bias) + sh24);
                    OP_M7: n_p10   = abkf_pkg::sat32(abkf_pkg::sx72(r_p10) - sh24);
                    OP_M8: n_p11   = abkf_pkg::sat32(abkf_pkg::sx72(r_p11) - sh24);
                    OP_M9: n_p00   = abkf_pkg::sat32(abkf_pkg::sx72(r_p00) - sh24);
                    OP_MA: n_p01   = abkf_pkg::sat32(abkf_pkg::sx72(r_p01) - sh24);
                    default: ;
                endcase
                if (r_op == OP_MA) begin
                    n_st = ST_FIN;
                end else begin
                    n_op = r_op + 4'd1;
                    n_st = ST_LOAD;
                end
            end
            ST_FIN: begin
                if (!r_ovalid || i_ready) begin
                    n_oang   = r_angle;
                    n_orate  = r_rate;
                    n_obias  = r_bias;
                    n_ovalid = 1'b1;
                    n_st     = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // Control and filter state, cleared at reset; the noise registers load their defaults.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_op     <= OP_M1;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_angle  <= '0;
            r_bias   <= '0;
            r_p00    <= '0;
            r_p01    <= '0;
            r_p10    <= '0;
            r_p11    <= '0;
            r_qa     <= abkf_pkg::ANGLE_Q_RST;
            r_qb     <= abkf_pkg::BIAS_Q_RST;
            r_rn     <= abkf_pkg::MEAS_R_RST;
        end else begin
            r_st     <= n_st;
            r_op     <= n_op;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_angle  <= n_angle;
            r_bias   <= n_bias;
            r_p00    <= n_p00;
            r_p01    <= n_p01;
            r_p10    <= n_p10;
            r_p11    <= n_p11;
            r_qa     <= n_qa;
            r_qb     <= n_qb;
            r_rn     <= n_rn;
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge i_clk) begin
        r_ma    <= n_ma;
        r_rate  <= n_rate;
        r_dp11  <= n_dp11;
        r_y     <= n_y;
        r_k0    <= n_k0;
        r_k1    <= n_k1;
        r_dt    <= n_dt;
        r_oang  <= n_oang;
        r_orate <= n_orate;
        r_obias <= n_obias;
        r_mcand <= n_mcand;
        r_acc   <= n_acc;
        r_neg   <= n_neg;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_quo   <= n_quo;
        r_dzero <= n_dzero;
        r_prod  <= n_prod;
    end

    // An accepted transaction starts with the first multiply.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_st == ST_LOAD && r_op == OP_M1))
        else $error("accepted transaction did not start the sequence");

    // The step counter stays inside the current operation's length.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_RUN) |-> (r_cnt < steps))
        else $error("serial step counter overran");

    // A result appears only when the sequence finishes.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_st) == ST_FIN))
        else $error("result shown outside the finish state");

    // A zero divisor gives a zero gain.
    a_dzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DONE && is_div && r_dzero) |-> (r_prod == '0))
        else $error("zero divisor produced a nonzero gain");

endmodule
`default_nettype wire

// ===== verif/angle_bias_kalman_filter_tb.sv =====
// Self-checking testbench for the angle and gyro bias Kalman filter.
`default_nettype none
module angle_bias_kalman_filter_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1000;
    localparam int HOLD_CYCLES    = 4000;
    localparam logic [abkf_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [abkf_pkg::CFG_W-1:0] CFG_MAX = 31'h7FFF_FFFF;

    typedef logic [abkf_pkg::CFG_W-1:0] t_cfg;
    typedef logic [abkf_pkg::IDX_W-1:0] t_idx;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [31:0] angle;
        logic [31:0] rate;
        logic [31:0] bias;
    } t_filter_out;

    // Scoreboard: a fixed-point copy of the filter plus the results it predicts.
    class filter_scoreboard;
        t_cfg q_angle, q_bias, r_meas;
        logic signed [31:0] est_angle, est_bias, p00, p01, p10, p11;
        t_filter_out expected_q[$];
        int errors;
        int checked;

        function new();
            q_angle = abkf_pkg::ANGLE_Q_RST;
            q_bias  = abkf_pkg::BIAS_Q_RST;
            r_meas  = abkf_pkg::MEAS_R_RST;
            est_angle = 0; est_bias = 0;
            p00 = 0; p01 = 0; p10 = 0; p11 = 0;
            errors = 0;
            checked = 0;
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return v[31:0];
        endfunction

        function logic signed [31:0] gain_of(longint num, longint den);
            if (den == 0) return 0;
            return clamp32((num * 64'sd16777216) / den);
        endfunction

        function void write_reg(t_idx idx, t_cfg data);
            case (idx)
                abkf_pkg::REG_ANGLE_Q: q_angle = data;
                abkf_pkg::REG_BIAS_Q:  q_bias  = data;
                abkf_pkg::REG_MEAS_R:  r_meas  = data;
                default: ;
            endcase
        endfunction

        // Predict the result of one accepted input transaction.
        function void note_input(logic [31:0] m_angle, logic [31:0] m_rate, logic [15:0] dt_in);
            longint dt, dp11, inner, y, s, a00, a01, a10, a11;
            logic signed [31:0] rate, k0, k1;
            t_filter_out res;
            dt = longint'(dt_in);
            rate = clamp32(longint'($signed(m_rate)) - longint'(est_bias));
            est_angle = clamp32(longint'(est_angle) + ((dt * longint'(rate)) >>> 16));
            // Covariance prediction uses the old P11 throughout.
            a00 = p00; a01 = p01; a10 = p10; a11 = p11;
            dp11 = (dt * a11) >>> 16;
            inner = dp11 - a01 - a10 + longint'(q_angle);
            p00 = clamp32(a00 + ((dt * inner) >>> 16));
            p01 = clamp32(a01 - dp11);
            p10 = clamp32(a10 - dp11);
            p11 = clamp32(a11 + ((longint'(q_bias) * dt) >>> 16));
            // Measurement update.
            y = longint'(clamp32(longint'($signed(m_angle)) - longint'(est_angle)));
            a00 = p00; a01 = p01; a10 = p10; a11 = p11;
            s = a00 + longint'(r_meas);
            k0 = gain_of(a00, s);
            k1 = gain_of(a10, s);
            est_angle = clamp32(longint'(est_angle) + ((longint'(k0) * y) >>> 24));
            est_bias  = clamp32(longint'(est_bias) + ((longint'(k1) * y) >>> 24));
            p00 = clamp32(a00 - ((longint'(k0) * a00) >>> 24));
            p01 = clamp32(a01 - ((longint'(k0) * a01) >>> 24));
            p10 = clamp32(a10 - ((longint'(k1) * a00) >>> 24));
            p11 = clamp32(a11 - ((longint'(k1) * a01) >>> 24));
            res.angle = est_angle;
            res.rate  = rate;
            res.bias  = est_bias;
            expected_q.push_back(res);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(logic [31:0] angle, logic [31:0] rate, logic [31:0] bias);
            t_filter_out exp_res;
            if (expected_q.size() == 0) begin
                $error("result with no expectation: angle=%h rate=%h bias=%h",
                       angle, rate, bias);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            if (angle !== exp_res.angle) begin
                $error("angle_output: expected %h actual %h", exp_res.angle, angle);
                errors++;
            end
            if (rate !== exp_res.rate) begin
                $error("unbiased_rate: expected %h actual %h", exp_res.rate, rate);
                errors++;
            end
            if (bias !== exp_res.bias) begin
                $error("bias_output: expected %h actual %h", exp_res.bias, bias);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_measured_angle;
    logic [31:0] i_measured_rate;
    logic [15:0] i_time_step;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_angle_output;
    logic [31:0] o_unbiased_rate;
    logic [31:0] o_bias_output;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [30:0] i_cfg_data;

    filter_scoreboard sb;
    t_idle_mode idle_mode;
    logic hold_req;
    int   sent_items;
    int   watchdog;

    angle_bias_kalman_filter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_measured_angle(i_measured_angle),
        .i_measured_rate (i_measured_rate),
        .i_time_step     (i_time_step),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_angle_output  (o_angle_output),
        .o_unbiased_rate (o_unbiased_rate),
        .o_bias_output   (o_bias_output),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Monitor both channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_input(i_measured_angle, i_measured_rate, i_time_step);
            end
            if (o_valid && i_ready) begin
                sb.check_result(o_angle_output, o_unbiased_rate, o_bias_output);
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            watchdog <= 0;
        end else begin
            watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Result side: random stalls per mode, and a long hold-off on request.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else if (idle_mode == IDLE_RECV) begin
                i_ready = ($urandom_range(0, 99) >= 77);
            end else if (idle_mode == IDLE_BOTH) begin
                i_ready = ($urandom_range(0, 99) >= 31);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // Send one input transaction; returns after it is accepted.
    task automatic send_item(logic [31:0] angle, logic [31:0] rate, logic [15:0] dt);
        int idle_pct;
        idle_pct = (idle_mode == IDLE_SEND) ? 77 : (idle_mode == IDLE_BOTH) ? 31 : 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_measured_angle = angle;
        i_measured_rate  = rate;
        i_time_step      = dt;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        sent_items++;
    endtask

    // Random item: mostly realistic IMU samples, some raw full-range values.
    task automatic send_random_item();
        logic [31:0] angle, rate;
        logic [15:0] dt;
        if ($urandom_range(0, 99) < 70) begin
            angle = $urandom_range(0, 11796480) - 5898240;
            rate  = $urandom_range(0, 65536000) - 32768000;
            dt    = 16'($urandom_range(1, 2000));
        end else begin
            angle = $urandom;
            rate  = $urandom;
            dt    = 16'($urandom_range(0, 65535));
        end
        send_item(angle, rate, dt);
    endtask

    // Stop sending and wait until every predicted result has been checked.
    task automatic wait_drained();
        i_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_idx idx, t_cfg data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_config(t_cfg qa, t_cfg qb, t_cfg r);
        wait_drained();
        write_reg(abkf_pkg::REG_ANGLE_Q, qa);
        write_reg(abkf_pkg::REG_BIAS_Q, qb);
        write_reg(abkf_pkg::REG_MEAS_R, r);
    endtask

    // Main sequence.
    initial begin
        sb = new();
        idle_mode = IDLE_NONE;
        hold_req = 1'b0;
        sent_items = 0;
        watchdog = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_measured_angle = '0;
        i_measured_rate = '0;
        i_time_step = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Zero divisor: no measurement noise and a zero covariance.
        write_reg(abkf_pkg::REG_MEAS_R, '0);
        send_item(32'h0001_0000, 32'h0000_8000, 16'd0);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
        // An unused register index must leave the settings alone.
        wait_drained();
        write_reg(REG_UNUSED, CFG_MAX);
        set_config(abkf_pkg::ANGLE_Q_RST, abkf_pkg::BIAS_Q_RST, abkf_pkg::MEAS_R_RST);

        // Field extremes.
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
        send_item(32'h8000_0000, 32'h8000_0000, 16'hFFFF);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 16'h0001);
        send_item(32'h0000_0000, 32'h0000_0000, 16'h0000);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(32'h0000_0000, 32'h0000_0000, 16'h8000);

        // Saturated covariances, and a divisor that can go negative.
        set_config(CFG_MAX, CFG_MAX, CFG_MAX);
        repeat (4) send_item(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        set_config('0, '0, CFG_MAX);
        repeat (3) send_item(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        set_config('0, '0, '0);
        repeat (3) send_item(32'h0100_0000, 32'hFF00_0000, 16'h1000);

        // Long hold-off on the result side while inputs keep coming.
        set_config(abkf_pkg::ANGLE_Q_RST, abkf_pkg::BIAS_Q_RST, abkf_pkg::MEAS_R_RST);
        hold_req = 1'b1;
        repeat (12) send_random_item();

        // Random phases over the idling modes and several settings.
        for (int phase = 0; phase < 8; phase++) begin
            idle_mode = t_idle_mode'(phase % 4);
            case (phase)
                1: set_config(CFG_MAX, CFG_MAX, CFG_MAX);
                2: set_config('0, '0, '0);
                3: set_config(t_cfg'($urandom), t_cfg'($urandom), t_cfg'($urandom));
                4: set_config(t_cfg'($urandom_range(0, 100000)),
                              t_cfg'($urandom_range(0, 100000)),
                              t_cfg'($urandom_range(0, 2000000)));
                5: set_config(t_cfg'($urandom), t_cfg'($urandom_range(0, 1000)),
                              t_cfg'($urandom_range(1, 100)));
                6: set_config(abkf_pkg::ANGLE_Q_RST, abkf_pkg::BIAS_Q_RST,
                              abkf_pkg::MEAS_R_RST);
                7: set_config(t_cfg'($urandom_range(0, 100000)), CFG_MAX,
                              t_cfg'($urandom));
                default: ;
            endcase
            repeat (150) send_random_item();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.expected_q.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_q.size());
            sb.errors++;
        end
        $display("Sent %0d samples over eight idling phases and corner settings;",
                 sent_items);
        $display("checked %0d filter results, %0d field errors.", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/abkf_pkg.sv
design/angle_bias_kalman_filter.sv
verif/angle_bias_kalman_filter_tb.sv
